FILE: hw/rtl/cubic_bezier_easing_solver_top_assert.svh
// Assertion macros for the easing solver.
`ifndef CUBIC_BEZIER_EASING_SOLVER_TOP_ASSERT_SVH
`define CUBIC_BEZIER_EASING_SOLVER_TOP_ASSERT_SVH
// same-cycle implication, clocked on clk, off during rst
`define CBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, clocked on clk, off during rst
`define CBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: hw/rtl/cbe_pkg.sv
// Shared constants and types for the cubic Bezier easing solver.
package cbe_pkg;
  localparam int FRAC_BITS_DEF    = 24;
  localparam int NEWTON_STEPS_DEF = 8;
  localparam int BISECT_STEPS_DEF = 20;
  localparam int IO_W             = 26;
  localparam int PX_W             = 25;
  localparam int PY_W             = 26;
  localparam int CFG_W            = 26;
  localparam int CFG_IDX_W        = 2;
  localparam int EPS_LSB          = 17;
  localparam int OUT_MAX          = 33554431;
  localparam int OUT_MIN          = -33554432;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CTRL1_X = 2'd0,
    REG_CTRL1_Y = 2'd1,
    REG_CTRL2_X = 2'd2,
    REG_CTRL2_Y = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic mul;
    logic add;
  } mac_ctl_t;
endpackage

FILE: hw/rtl/cbe_stream_if.sv
// Valid/ready stream interfaces for progress in and eased result out.
interface cbe_progress_if
  import cbe_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [IO_W-1:0] progress;
  modport source (output valid, output progress, input ready);
  modport sink (input valid, input progress, output ready);
endinterface

interface cbe_eased_if
  import cbe_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [IO_W-1:0] eased;
  modport source (output valid, output eased, input ready);
  modport sink (input valid, input eased, output ready);
endinterface

FILE: hw/rtl/cbe_mac.sv
// Shared multiply-shift-add unit: acc = sat(floor(a*t / 2^F) + addend); the product is registered, then the sum.
module cbe_mac
  import cbe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int W         = FRAC_BITS_DEF + 10,
  parameter int CW        = FRAC_BITS_DEF + 10,
  parameter int TW        = FRAC_BITS_DEF + 2
) (
  input  logic                 clk,
  input  mac_ctl_t             ctl,
  input  logic signed [CW-1:0] op_a,
  input  logic signed [TW-1:0] op_t,
  input  logic signed [CW-1:0] addend,
  output logic signed [W-1:0]  acc
);
  localparam int PW = CW + TW;
  localparam int SW = CW + 3;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_sh;
  logic signed [SW-1:0] sum;

  always_comb begin
    prod_sh = prod >>> FRAC_BITS;
    sum     = SW'(prod_sh) + SW'(addend);
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= op_a * op_t;
    end
    if (ctl.add) begin
      if (sum > SAT_HI) begin
        acc <= SAT_HI[W-1:0];
      end else if (sum < SAT_LO) begin
        acc <= SAT_LO[W-1:0];
      end else begin
        acc <= sum[W-1:0];
      end
    end
  end
endmodule

FILE: hw/rtl/cbe_div.sv
// Restoring divider: n/d in fixed point, truncated toward zero, magnitude limited to 4.0.
module cbe_div
  import cbe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int W         = FRAC_BITS_DEF + 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [W:0]         num,
  input  logic signed [W-1:0]       den,
  output logic                      done,
  output logic signed [FRAC_BITS+3:0] quo
);
  localparam int RW   = W + 3;
  localparam int QM   = FRAC_BITS + 3;
  localparam int CNTW = $clog2(FRAC_BITS + 2);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [RW-1:0]   rem;
  logic [RW-1:0]   d4;
  logic [QM-1:0]   qmag;
  logic            neg;
  logic [W:0]      un;
  logic [W-1:0]    ud;
  logic [RW-1:0]   d4_start;
  logic [RW-1:0]   rem_sh;
  logic            qbit;

  always_comb begin
    un       = num[W] ? (W+1)'(-num) : (W+1)'(num);
    ud       = den[W-1] ? W'(-den) : W'(den);
    d4_start = RW'(ud) << 2;
    rem_sh   = rem << 1;
    qbit     = rem_sh >= d4;
    quo      = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= num[W] != den[W-1];
        d4  <= d4_start;
        cnt <= '0;
        if (RW'(un) >= d4_start) begin
          qmag <= QM'(1) << (FRAC_BITS + 2);
          done <= 1'b1;
        end else begin
          qmag <= '0;
          rem  <= RW'(un);
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem  <= qbit ? rem_sh - d4 : rem_sh;
        qmag <= {qmag[QM-2:0], qbit};
        cnt  <= cnt + 1'b1;
        if (cnt == CNTW'(FRAC_BITS + 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: hw/rtl/cubic_bezier_easing_solver_top.sv
// Top level of the cubic Bezier easing solver: sequencer, config and output register.
// Usage:
//  - in_ch carries one progress value x (signed Q FRAC_BITS) per transfer; out_ch
//    returns one eased value y per input, in order.
//  - in_ch.ready is high only while the sequencer is idle; one item is worked on at
//    a time on a shared multiply-add unit and a bit-serial divider.
//  - x <= 0 or x >= 1.0 skip the solver: the result is registered at the transfer, then
//    loaded into the output register. Otherwise every polynomial evaluation takes a
//    multiply state and an add state per multiply-add plus a decision state; a Newton
//    step also waits on the divider, a bisection step does not.
//  - The result sits in an output register; the next progress value is taken while
//    it waits, and the sequencer holds its finished result until the register frees.
//  - Configuration (cfg_we/cfg_index/cfg_wdata) is written while idle; coefficients
//    are derived from the control points when an item is taken.
//  - Reset (rst, synchronous) returns to idle, clears the output valid and loads the
//    control points (0,0) and (1,1).
module cubic_bezier_easing_solver_top
  import cbe_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int NEWTON_STEPS = NEWTON_STEPS_DEF,
  parameter int BISECT_STEPS = BISECT_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  cbe_progress_if.sink         in_ch,
  cbe_eased_if.source          out_ch
);
  localparam int W    = FRAC_BITS + 10;
  localparam int CW   = (W > 33) ? W : 33;
  localparam int TW   = FRAC_BITS + 2;
  localparam int EW   = W + 1;
  localparam int QW   = FRAC_BITS + 4;
  localparam int XW   = (TW > 27) ? TW : 27;
  localparam int MAXS = (NEWTON_STEPS > BISECT_STEPS) ? NEWTON_STEPS : BISECT_STEPS;
  localparam int IW   = $clog2(MAXS + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL    = 6'b000010,
    S_ADD    = 6'b000100,
    S_DECIDE = 6'b001000,
    S_DIV    = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    JOB_X = 2'd0,
    JOB_D = 2'd1,
    JOB_Y = 2'd2
  } job_t;

  // control point registers
  logic [PX_W-1:0]        p1x, p2x;
  logic signed [PY_W-1:0] p1y, p2y;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1x <= '0;
      p1y <= '0;
      p2x <= PX_W'(1) << 24;
      p2y <= PY_W'(1) << 24;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CTRL1_X: p1x <= cfg_wdata[PX_W-1:0];
        REG_CTRL1_Y: p1y <= $signed(cfg_wdata[PY_W-1:0]);
        REG_CTRL2_X: p2x <= cfg_wdata[PX_W-1:0];
        REG_CTRL2_Y: p2y <= $signed(cfg_wdata[PY_W-1:0]);
        default: ;
      endcase
    end
  end

  // polynomial coefficients from the control points
  logic signed [CW-1:0] one_c, p1x_w, p2x_w, p1y_w, p2y_w, dx, dy;
  logic signed [CW-1:0] cx_n, bx_n, ax_n, cy_n, by_n, ay_n;
  logic signed [CW-1:0] ax, bx, cx, ax3, bx2, ay, by, cy;

  always_comb begin
    one_c = CW'(1) <<< FRAC_BITS;
    p1x_w = $signed(CW'(p1x));
    p2x_w = $signed(CW'(p2x));
    p1y_w = CW'(p1y);
    p2y_w = CW'(p2y);
    dx    = p2x_w - p1x_w;
    dy    = p2y_w - p1y_w;
    cx_n  = p1x_w + (p1x_w <<< 1);
    bx_n  = dx + (dx <<< 1) - cx_n;
    ax_n  = one_c - cx_n - bx_n;
    cy_n  = p1y_w + (p1y_w <<< 1);
    by_n  = dy + (dy <<< 1) - cy_n;
    ay_n  = one_c - cy_n - by_n;
  end

  state_t               state;
  job_t                 job;
  logic [1:0]           op;
  logic                 bisect;
  logic [IW-1:0]        iter;
  logic signed [TW-1:0] x_t, t, tl, tr;
  logic signed [EW-1:0] e_q;
  logic signed [IO_W-1:0] res;
  logic                 out_valid;
  logic signed [IO_W-1:0] eased_q;

  // mac operand selection
  mac_ctl_t             mac_ctl;
  logic signed [CW-1:0] op_a, addend, coef, cb, cc;
  logic signed [W-1:0]  acc;
  logic [1:0]           last_op;

  always_comb begin
    case (job)
      JOB_X: begin coef = ax;  cb = bx;  cc = cx; last_op = 2'd2; end
      JOB_D: begin coef = ax3; cb = bx2; cc = cx; last_op = 2'd1; end
      JOB_Y: begin coef = ay;  cb = by;  cc = cy; last_op = 2'd2; end
      default: begin coef = ax; cb = bx; cc = cx; last_op = 2'd2; end
    endcase
    op_a    = (op == 2'd0) ? coef : CW'(acc);
    addend  = (op == 2'd0) ? cb : ((op == 2'd1) ? cc : '0);
    mac_ctl.mul = state == S_MUL;
    mac_ctl.add = state == S_ADD;
  end

  cbe_mac #(
    .FRAC_BITS(FRAC_BITS), .W(W), .CW(CW), .TW(TW)
  ) u_mac (
    .clk(clk), .ctl(mac_ctl), .op_a(op_a), .op_t(t), .addend(addend), .acc(acc)
  );

  // decision terms
  logic signed [EW-1:0] e_full, e_mag;
  logic signed [W-1:0]  d_mag;
  logic                 e_small, d_small, x_above;
  logic signed [TW-1:0] tl_n, tr_n, mid, one_t;

  always_comb begin
    e_full  = EW'(acc) - EW'(x_t);
    e_mag   = e_full[EW-1] ? -e_full : e_full;
    d_mag   = acc[W-1] ? -acc : acc;
    e_small = e_mag < EW'(EPS_LSB);
    d_small = $unsigned(d_mag) < W'(EPS_LSB);
    x_above = EW'(x_t) > EW'(acc);
    tl_n    = x_above ? t : tl;
    tr_n    = x_above ? tr : t;
    mid     = tl_n + ((tr_n - tl_n) >>> 1);
    one_t   = TW'(1) <<< FRAC_BITS;
  end

  // divider
  logic                 div_start, div_done;
  logic signed [QW-1:0] div_quo;
  logic signed [TW+2:0] t_sub;
  logic signed [TW+2:0] t_lim;
  logic signed [TW-1:0] t_newton;

  assign div_start = (state == S_DECIDE) && (job == JOB_D) && !d_small;

  cbe_div #(.FRAC_BITS(FRAC_BITS), .W(W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(e_q), .den(acc),
    .done(div_done), .quo(div_quo)
  );

  // t clamped to [-2.0, 2.0 - 1 LSB]
  always_comb begin
    t_sub = (TW+3)'(t) - (TW+3)'(div_quo);
    t_lim = (TW+3)'(one_t) <<< 1;
    if (t_sub > t_lim - (TW+3)'(1)) begin
      t_newton = $signed({1'b0, {(TW-1){1'b1}}});
    end else if (t_sub < -t_lim) begin
      t_newton = $signed({1'b1, {(TW-1){1'b0}}});
    end else begin
      t_newton = t_sub[TW-1:0];
    end
  end

  function automatic logic signed [IO_W-1:0] sat_out(input logic signed [W-1:0] v);
    if (v > W'(OUT_MAX)) begin
      return IO_W'(OUT_MAX);
    end else if (v < W'(OUT_MIN)) begin
      return IO_W'(OUT_MIN);
    end
    return v[IO_W-1:0];
  endfunction

  // input checks at the transfer
  logic                 in_xfer, out_load;
  logic signed [XW-1:0] prog_x, one_x;

  always_comb begin
    in_xfer  = in_ch.valid && in_ch.ready;
    out_load = (state == S_OUT) && (!out_valid || out_ch.ready);
    prog_x   = XW'(in_ch.progress);
    one_x    = XW'(1) <<< FRAC_BITS;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      job    <= JOB_X;
      op     <= 2'd0;
      bisect <= 1'b0;
      iter   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            ax  <= ax_n;
            bx  <= bx_n;
            cx  <= cx_n;
            ax3 <= ax_n + (ax_n <<< 1);
            bx2 <= bx_n <<< 1;
            ay  <= ay_n;
            by  <= by_n;
            cy  <= cy_n;
            x_t <= TW'(in_ch.progress);
            t   <= TW'(in_ch.progress);
            job    <= JOB_X;
            op     <= 2'd0;
            bisect <= 1'b0;
            iter   <= '0;
            if (prog_x <= XW'(0)) begin
              res   <= '0;
              state <= S_OUT;
            end else if (prog_x >= one_x) begin
              res   <= sat_out(W'(1) <<< FRAC_BITS);
              state <= S_OUT;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: state <= S_ADD;
        S_ADD: begin
          if (op == last_op) begin
            op    <= 2'd0;
            state <= S_DECIDE;
          end else begin
            op    <= op + 2'd1;
            state <= S_MUL;
          end
        end
        S_DECIDE: begin
          case (job)
            JOB_X: begin
              if (e_small) begin
                job   <= JOB_Y;
                state <= S_MUL;
              end else if (!bisect) begin
                e_q   <= e_full;
                job   <= JOB_D;
                state <= S_MUL;
              end else begin
                tl    <= tl_n;
                tr    <= tr_n;
                t     <= mid;
                iter  <= iter + 1'b1;
                job   <= (iter == IW'(BISECT_STEPS - 1)) ? JOB_Y : JOB_X;
                state <= S_MUL;
              end
            end
            JOB_D: begin
              if (d_small) begin
                bisect <= 1'b1;
                tl     <= '0;
                tr     <= one_t;
                t      <= x_t;
                iter   <= '0;
                job    <= JOB_X;
                state  <= S_MUL;
              end else begin
                state <= S_DIV;
              end
            end
            default: begin
              res   <= sat_out(acc);
              state <= S_OUT;
            end
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            job <= JOB_X;
            if (iter == IW'(NEWTON_STEPS - 1)) begin
              // Newton budget spent: bisection restarts from t = x
              bisect <= 1'b1;
              tl     <= '0;
              tr     <= one_t;
              t      <= x_t;
              iter   <= '0;
            end else begin
              t    <= t_newton;
              iter <= iter + 1'b1;
            end
            state <= S_MUL;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      eased_q <= res;
    end
  end

  assign in_ch.ready  = state == S_IDLE;
  assign out_ch.valid = out_valid;
  assign out_ch.eased = eased_q;

`include "cubic_bezier_easing_solver_top_assert.svh"

  `CBE_ASSERT_NEXT(a_busy_after_take, in_xfer, state != S_IDLE, "idle after input transfer")
  `CBE_ASSERT_NOW(a_div_done_in_div, div_done, state == S_DIV, "divider finished outside wait")
  `CBE_ASSERT_NEXT(a_out_loaded, out_load, out_valid && state == S_IDLE, "result not presented")
endmodule
